// ===== hw/rtl/acrq_pkg.sv =====
// Shared types, constants and helper functions of the ADC change report queue.
package acrq_pkg;

  // Field widths of the input and result beats.
  localparam int STEP_W   = 4;
  localparam int SAMPLE_W = 12;
  localparam int MUX_W    = 3;
  localparam int STATUS_W = 3;
  localparam int CHAN_W   = 4;
  localparam int VAL_W    = 7;
  localparam int DROP_W   = 32;
  localparam int FILL_W   = 11;
  localparam int ENTRY_W  = CHAN_W + VAL_W;

  // Channel set and the number of low bits that are dropped from each sample.
  localparam int NUM_CHANNELS = 14;
  localparam int VAL_SHIFT    = 5;

  // Ring geometry. Pointers run modulo twice the depth.
  localparam int RING_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int PTR_W      = $clog2(2 * RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_CHANNEL_ENABLE = 1'b0;
  localparam logic [NUM_CHANNELS-1:0] ENABLE_RESET = '1;

  // Step tags with a special channel mapping.
  localparam logic [STEP_W-1:0] STEP_DIRECT_MAX = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUXED      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_AUX        = 4'd6;
  localparam logic [CHAN_W-1:0] CH_MUX_BASE     = 4'd5;
  localparam logic [CHAN_W-1:0] CH_MUX_ZERO     = 4'd13;
  localparam logic [CHAN_W-1:0] CH_AUX          = 4'd5;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  // Requests from the sample stage to the ring, valid for one advancing beat.
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [ENTRY_W-1:0] entry;
  } ring_req_t;

  // Ring state seen by the sample stage, with the values after this beat.
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [CNT_W-1:0]  held_next;
    logic [DROP_W-1:0] drop_next;
  } ring_stat_t;

  typedef struct packed {
    logic              hit;
    logic [CHAN_W-1:0] chan;
  } chan_map_t;

  // Maps a sequencer step and the mux setting to a channel; steps above six miss.
  function automatic chan_map_t map_channel(input logic [STEP_W-1:0] step,
                                            input logic [MUX_W-1:0] mux);
    chan_map_t m;
    m.hit  = 1'b1;
    m.chan = '0;
    case (step)
      STEP_MUXED: begin
        m.chan = (mux == '0) ? CH_MUX_ZERO : CH_MUX_BASE + CHAN_W'(mux);
      end
      STEP_AUX: begin
        m.chan = CH_AUX;
      end
      default: begin
        if (step inside {[4'd0:STEP_DIRECT_MAX]}) begin
          m.chan = CHAN_W'(step);
        end else begin
          m.hit = 1'b0;
        end
      end
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/acrq_cfg.sv =====
// APB-style configuration register holding the channel enable mask.
module acrq_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acrq_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [acrq_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [acrq_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [acrq_pkg::NUM_CHANNELS-1:0] enable_mask
);
  import acrq_pkg::*;

  logic reg_sel;
  logic wr_en;

  // Registers sit one word apart; the word index is the address bit above the byte lanes.
  assign reg_sel = (paddr[2] == REG_CHANNEL_ENABLE);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  // Mask register, written in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= ENABLE_RESET;
    end else if (wr_en) begin
      enable_mask <= pwdata[NUM_CHANNELS-1:0];
    end
  end

  // Read data; addresses with address bit 2 set read as zero.
  assign prdata = reg_sel ? CFG_DATA_W'(enable_mask) : '0;

endmodule

// ===== hw/rtl/acrq_ring.sv =====
// Message ring with wrap-bit pointers, drop counter and registered read port.
module acrq_ring (
  input  logic                         clk,
  input  logic                         rst,
  input  acrq_pkg::ring_req_t          req,
  output acrq_pkg::ring_stat_t         stat,
  output logic [acrq_pkg::ENTRY_W-1:0] rd_entry
);
  import acrq_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * RING_DEPTH - 1);
  localparam logic [PTR_W:0]   PTR_SPAN = (PTR_W + 1)'(2 * RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(RING_DEPTH);

  logic [ENTRY_W-1:0] mem [RING_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [DROP_W-1:0]  drop_cnt, drop_cnt_next;
  logic [CNT_W-1:0]   held_cnt;
  logic               push, pop, drop;

  // Entries held between two pointers that count modulo twice the depth.
  function automatic logic [CNT_W-1:0] held_of(input logic [PTR_W-1:0] w,
                                               input logic [PTR_W-1:0] r);
    logic [PTR_W:0] diff;
    if (w >= r) begin
      diff = {1'b0, w} - {1'b0, r};
    end else begin
      diff = {1'b0, w} + PTR_SPAN - {1'b0, r};
    end
    return CNT_W'(diff);
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    return (p >= PTR_HALF) ? ADDR_W'(p - PTR_HALF) : ADDR_W'(p);
  endfunction

  // Occupancy and the push, pop and drop decisions for this beat.
  assign held_cnt = held_of(wr_ptr, rd_ptr);
  assign push     = req.wr && !stat.full;
  assign drop     = req.wr && stat.full;
  assign pop      = req.rd && !stat.empty;

  always_comb begin
    wr_ptr_next   = push ? advance(wr_ptr) : wr_ptr;
    rd_ptr_next   = pop ? advance(rd_ptr) : rd_ptr;
    drop_cnt_next = drop ? drop_cnt + 1'b1 : drop_cnt;
  end

  assign stat.empty     = (wr_ptr == rd_ptr);
  assign stat.full      = (held_cnt == CNT_W'(RING_DEPTH));
  assign stat.held_next = held_of(wr_ptr_next, rd_ptr_next);
  assign stat.drop_next = drop_cnt_next;

  // Pointers and drop counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      drop_cnt <= '0;
    end else begin
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      drop_cnt <= drop_cnt_next;
    end
  end

  // Storage; read data is registered and held until the next pop.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[slot_of(wr_ptr)] <= req.entry;
    end
    if (pop) begin
      rd_entry <= mem[slot_of(rd_ptr)];
    end
  end

`ifndef SYNTHESIS
  a_held_bounded: assert property (@(posedge clk) disable iff (rst)
    held_cnt <= CNT_W'(RING_DEPTH))
    else $error("ring holds more entries than its depth");

  a_rd_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(rd_ptr))
    else $error("read pointer moved without a pop");

  a_push_not_empty: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !stat.empty)
    else $error("ring empty right after a push");
`endif

endmodule

// ===== hw/rtl/adc_change_report_queue.sv =====
// Top level of the ADC change report queue: input stage, change detect and result stage.
//
// Input beats arrive on the s_ group. s_tuser carries the operation: a sample
// (step tag, 12-bit value, mux setting in s_tdata) or a pop of one queued message.
// Each sample is mapped to one of 14 channels; when an enabled channel's value
// shifted right by five bits changes, a channel and value message is queued in a
// 1024-entry ring, or dropped and counted when the ring is full.
// Every input beat yields exactly one result beat on the m_ group: m_tuser holds
// the status, m_tdata the message, the drop count and the ring fill level.
// The channel enable mask is written through the APB-style port.
// From input beat to result beat there is one input register and one result
// register, with the ring read data registered alongside the result.
// Throughput is one beat per cycle while the receiver does not stall; the state
// update and the ring pointer logic sit in the single stage between the two registers.
// Reset empties the ring, clears the stored channel values and the drop count,
// and enables every channel; it needs no clearing pass.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and s_tready drops until m_tready returns.
module adc_change_report_queue (
  input  logic                            clk,
  input  logic                            rst,
  // Input beats.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // step_id[3:0], sample_value[15:4], mux_select[18:16]
  input  logic                            s_tuser,  // op[0]
  // Result beats.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [55:0]                     m_tdata,  // msg_channel[3:0], msg_value[10:4], drop_count[42:11], fill_level[53:43]
  output logic [acrq_pkg::STATUS_W-1:0]   m_tuser,  // status[2:0]
  // Configuration.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [acrq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [acrq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [acrq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import acrq_pkg::*;

  logic [NUM_CHANNELS-1:0] enable_mask;

  logic                s1_valid;
  op_t                 s1_op;
  logic [STEP_W-1:0]   s1_step;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [MUX_W-1:0]    s1_mux;

  logic                out_valid;
  status_t             out_status;
  logic [CHAN_W-1:0]   out_chan;
  logic [VAL_W-1:0]    out_val;
  logic [DROP_W-1:0]   out_drop;
  logic [FILL_W-1:0]   out_fill;
  logic                out_from_ring;

  logic [VAL_W-1:0]    last_value [NUM_CHANNELS];

  ring_req_t           ring_req;
  ring_stat_t          ring_stat;
  logic [ENTRY_W-1:0]  ring_entry;

  chan_map_t           cmap;
  logic [VAL_W-1:0]    trunc_val;
  logic                changed;
  logic                is_pop;
  status_t             status_next;
  logic                out_ready;
  logic                s1_adv;

  logic [CHAN_W-1:0]   msg_chan;
  logic [VAL_W-1:0]    msg_val;

  acrq_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .enable_mask (enable_mask)
  );

  // Pipeline flow: the result register frees up when empty or taken.
  assign out_ready = !out_valid || m_tready;
  assign s1_adv    = s1_valid && out_ready;
  assign s_tready  = !s1_valid || out_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op     <= op_t'(s_tuser);
      s1_step   <= s_tdata[3:0];
      s1_sample <= s_tdata[15:4];
      s1_mux    <= s_tdata[18:16];
    end
  end

  // Channel mapping and change detection.
  assign cmap      = map_channel(s1_step, s1_mux);
  assign trunc_val = s1_sample[SAMPLE_W-1:VAL_SHIFT];
  assign is_pop    = (s1_op == OP_POP);
  assign changed   = !is_pop && cmap.hit && enable_mask[cmap.chan]
                     && (last_value[cmap.chan] != trunc_val);

  // Ring requests go out only on the beat that moves into the result register.
  assign ring_req.wr    = s1_adv && changed;
  assign ring_req.rd    = s1_adv && is_pop;
  assign ring_req.entry = {cmap.chan, trunc_val};

  acrq_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .req      (ring_req),
    .stat     (ring_stat),
    .rd_entry (ring_entry)
  );

  // Status of this beat.
  always_comb begin
    if (is_pop) begin
      status_next = ring_stat.empty ? ST_EMPTY : ST_POPPED;
    end else if (changed) begin
      status_next = ring_stat.full ? ST_DROPPED : ST_QUEUED;
    end else begin
      status_next = ST_NONE;
    end
  end

  // Last reported value per channel; kept even when the message is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_value[i] <= '0;
      end
    end else if (s1_adv && changed) begin
      last_value[cmap.chan] <= trunc_val;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status    <= status_next;
      out_chan      <= changed ? cmap.chan : '0;
      out_val       <= changed ? trunc_val : '0;
      out_drop      <= ring_stat.drop_next;
      out_fill      <= FILL_W'(ring_stat.held_next);
      out_from_ring <= is_pop && !ring_stat.empty;
    end
  end

  // A popped message comes from the ring's registered read data.
  assign msg_chan = out_from_ring ? ring_entry[ENTRY_W-1:VAL_W] : out_chan;
  assign msg_val  = out_from_ring ? ring_entry[VAL_W-1:0] : out_val;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {2'b0, out_fill, out_drop, msg_val, msg_chan};

`ifndef SYNTHESIS
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    s1_adv && is_pop && ring_stat.empty |=> out_status == ST_EMPTY)
    else $error("pop on an empty ring not reported as empty");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    s1_adv && changed && ring_stat.full |=> out_status == ST_DROPPED && out_valid)
    else $error("change on a full ring not reported as dropped");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_NONE || out_status == ST_EMPTY)
    |-> msg_chan == '0 && msg_val == '0)
    else $error("message fields not zero on a beat without a message");
`endif

endmodule
